// File: src/chained_hash_table_engine_unit_defines.svh
// Assertion macros shared by the hash table engine modules.
// Depends on nothing; included by files that carry assertions.
`ifndef CHAINED_HASH_TABLE_ENGINE_UNIT_DEFINES_SVH
`define CHAINED_HASH_TABLE_ENGINE_UNIT_DEFINES_SVH

// Implication checked at every clock edge outside reset.
`define CHT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequence is checked in the clock cycle after the antecedent.
`define CHT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/cht_pkg.sv
// Package for the chained hash table engine: constants, widths and codes.
// Depends on nothing.
package cht_pkg;

    localparam int NUM_BUCKETS_DEF  = 16;
    localparam int BUCKET_DEPTH_DEF = 8;
    localparam int KEY_WIDTH_DEF    = 16;

    localparam int IN_KEY_W = 16;
    localparam int BIDX_W   = 4;
    localparam int STATUS_W = 2;
    localparam int CNT_W    = 5;
    localparam int MODE_W   = 2;

    localparam logic [0:0] CFG_HASH_MODE    = 1'b0;
    localparam logic [0:0] CFG_BUCKET_COUNT = 1'b1;

    localparam logic [1:0] MODE_MOD   = 2'd0;
    localparam logic [1:0] MODE_SQUARE = 2'd1;
    localparam logic [1:0] MODE_SQRT  = 2'd2;
    localparam logic [1:0] MODE_MOD3  = 2'd3;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_DELETE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_INSERTED  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DELETED   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

    localparam int HASH_W = 32;

endpackage

// File: src/cht_front.sv
// Front end of the hash table engine: accepts words and computes the bucket.
// Uses cht_pkg. Square, square root and modulo run one step per cycle.
module cht_front #(
    parameter int NUM_BUCKETS = cht_pkg::NUM_BUCKETS_DEF,
    parameter int KEY_WIDTH   = cht_pkg::KEY_WIDTH_DEF,
    parameter int BKT_W       = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [cht_pkg::MODE_W-1:0]   hash_mode,
    input  logic [cht_pkg::CNT_W-1:0]    bucket_count,
    input  logic                         valid,
    output logic                         ready,
    input  logic                         func,
    input  logic [cht_pkg::IN_KEY_W-1:0] key,
    output logic                         q_valid,
    input  logic                         q_ready,
    output logic                         q_func,
    output logic [KEY_WIDTH-1:0]         q_key,
    output logic [BKT_W-1:0]             q_bucket
);
    import cht_pkg::*;

    localparam int SQ_W  = 2 * KEY_WIDTH;
    localparam int RT_W  = KEY_WIDTH;
    localparam int NB_W  = $clog2(NUM_BUCKETS + 1);
    localparam int STEP_W = $clog2(SQ_W + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SQR  = 3'd1;
    localparam logic [2:0] S_ROOT = 3'd2;
    localparam logic [2:0] S_MOD  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]           state_reg, state_next;
    logic                 func_reg;
    logic [KEY_WIDTH-1:0] key_reg;
    logic [SQ_W-1:0]      val_reg;     // dividend for the modulo, or square accumulator
    logic [RT_W+1:0]      rem_reg;     // square root remainder
    logic [RT_W-1:0]      root_reg;
    logic [NB_W-1:0]      div_reg;
    logic [NB_W:0]        mrem_reg;
    logic [STEP_W-1:0]    step_reg;
    logic [BKT_W-1:0]     bkt_reg;

    logic [NB_W-1:0]      n_eff;
    logic [KEY_WIDTH-1:0] key_m;
    logic [RT_W+1:0]      rt_trial, rt_rem;
    logic [NB_W:0]        m_sh;
    logic [NB_W:0]        m_next;
    logic [BKT_W-1:0]     bkt_final;

    assign key_m = KEY_WIDTH'(key);

    always_comb
    begin
        if (bucket_count == '0)
            n_eff = NB_W'(1);
        else if (32'(bucket_count) > NUM_BUCKETS)
            n_eff = NB_W'(NUM_BUCKETS);
        else
            n_eff = NB_W'(bucket_count);
    end

    assign rt_rem   = {rem_reg[RT_W-1:0], val_reg[KEY_WIDTH-1 -: 2]};
    assign rt_trial = {root_reg, 2'b01};
    assign m_sh     = {mrem_reg[NB_W-1:0], val_reg[SQ_W-1]};
    assign m_next   = (m_sh >= {1'b0, div_reg}) ? m_sh - {1'b0, div_reg} : m_sh;

    always_comb
    begin
        bkt_final = BKT_W'(m_next);
        if (div_reg == NB_W'(3) && NB_W'(3) > n_eff)
        begin
            // Mod three result at or above the bucket count: reduce once more.
            if (n_eff == NB_W'(1))
                bkt_final = '0;
            else if (m_next == (NB_W+1)'(2))
                bkt_final = '0;
        end
    end

    assign ready = (state_reg == S_IDLE);
    assign q_valid  = (state_reg == S_OUT);
    assign q_func   = func_reg;
    assign q_key    = key_reg;
    assign q_bucket = bkt_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (valid)
                begin
                    if (hash_mode == MODE_SQUARE)
                        state_next = S_SQR;
                    else if (hash_mode == MODE_SQRT)
                        state_next = S_ROOT;
                    else
                        state_next = S_MOD;
                end
            end
            S_SQR:  if (step_reg == STEP_W'(KEY_WIDTH - 1)) state_next = S_MOD;
            S_ROOT: if (step_reg == STEP_W'(KEY_WIDTH / 2 - 1)) state_next = S_MOD;
            S_MOD:  if (step_reg == STEP_W'(SQ_W - 1)) state_next = S_OUT;
            S_OUT:  if (q_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                S_IDLE:
                begin
                    func_reg <= func;
                    key_reg  <= key_m;
                    div_reg  <= (hash_mode == MODE_MOD3) ? NB_W'(3) : n_eff;
                    mrem_reg <= '0;
                    step_reg <= '0;
                    rem_reg  <= '0;
                    root_reg <= '0;
                    val_reg  <= (valid && hash_mode == MODE_SQUARE) ? '0 : SQ_W'(key_m);
                end
                S_SQR:
                begin
                    // Shift-add multiply, most significant multiplier bit first.
                    if (key_reg[KEY_WIDTH - 1 - int'(step_reg)])
                        val_reg <= {val_reg[SQ_W-2:0], 1'b0} + SQ_W'(key_reg);
                    else
                        val_reg <= {val_reg[SQ_W-2:0], 1'b0};
                    step_reg <= (state_next == S_MOD) ? '0 : step_reg + 1'b1;
                end
                S_ROOT:
                begin
                    if (rt_rem >= rt_trial)
                    begin
                        rem_reg  <= rt_rem - rt_trial;
                        root_reg <= {root_reg[RT_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg  <= rt_rem;
                        root_reg <= {root_reg[RT_W-2:0], 1'b0};
                    end
                    if (state_next == S_MOD)
                    begin
                        step_reg <= '0;
                        val_reg  <= SQ_W'({root_reg[RT_W-2:0],
                                           (rt_rem >= rt_trial)});
                    end
                    else
                    begin
                        step_reg <= step_reg + 1'b1;
                        val_reg  <= {val_reg[SQ_W-3:0], 2'b00};
                    end
                end
                S_MOD:
                begin
                    // Restoring remainder, one dividend bit per cycle.
                    mrem_reg <= m_next;
                    val_reg  <= {val_reg[SQ_W-2:0], 1'b0};
                    step_reg <= step_reg + 1'b1;
                    if (state_next == S_OUT)
                        bkt_reg <= bkt_final;
                end
                S_OUT: ;
                default: ;
            endcase
        end
    end

    `include "chained_hash_table_engine_unit_defines.svh"
    `CHT_ASSERT_IMP(a_front_idle_ready, clk, rst_n, state_reg == S_OUT, !ready, "front busy but ready")
    `CHT_ASSERT_NEXT(a_front_hold, clk, rst_n, q_valid && !q_ready, q_valid && $stable(q_bucket), "queue word changed")
    `CHT_ASSERT_IMP(a_front_range, clk, rst_n, q_valid, 32'(q_bucket) < NUM_BUCKETS, "bucket out of range")

endmodule

// File: src/cht_queue.sv
// Two-entry queue between front and back of the hash table engine.
// Uses cht_pkg for the default widths only.
module cht_queue #(
    parameter int WIDTH = cht_pkg::KEY_WIDTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);
    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_reg, rd_reg;
    logic [1:0]       cnt_reg;
    logic             push, pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_data  = mem_reg[rd_reg];
    assign push = in_valid && in_ready;
    assign pop  = out_valid && out_ready;

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= in_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push) wr_reg <= ~wr_reg;
            if (pop)  rd_reg <= ~rd_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end
endmodule

// File: src/cht_back.sv
// Back end of the hash table engine: key memory, fill counts and the bucket scan.
// Uses cht_pkg. One key memory read per cycle; delete shifts later keys up one slot.
module cht_back #(
    parameter int NUM_BUCKETS  = cht_pkg::NUM_BUCKETS_DEF,
    parameter int BUCKET_DEPTH = cht_pkg::BUCKET_DEPTH_DEF,
    parameter int KEY_WIDTH    = cht_pkg::KEY_WIDTH_DEF,
    parameter int BKT_W        = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_valid,
    output logic                         q_ready,
    input  logic                         q_func,
    input  logic [KEY_WIDTH-1:0]         q_key,
    input  logic [BKT_W-1:0]             q_bucket,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [cht_pkg::BIDX_W-1:0]   bucket_index,
    output logic [cht_pkg::STATUS_W-1:0] status
);
    import cht_pkg::*;

    localparam int SLOT_W = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
    localparam int FILL_W = $clog2(BUCKET_DEPTH + 1);
    localparam int ADDR_W = BKT_W + SLOT_W;
    localparam int ENTRIES = NUM_BUCKETS * (1 << SLOT_W);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_READ  = 3'd1;
    localparam logic [2:0] S_CMP   = 3'd2;
    localparam logic [2:0] S_SHIFT = 3'd3;
    localparam logic [2:0] S_WRITE = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;
    localparam logic [2:0] S_MOVE  = 3'd6;

    logic [KEY_WIDTH-1:0] keys_mem [ENTRIES];
    logic [FILL_W-1:0]    fill_reg [NUM_BUCKETS];

    logic [2:0]           state_reg;
    logic                 func_reg;
    logic [KEY_WIDTH-1:0] key_reg;
    logic [BKT_W-1:0]     bkt_reg;
    logic [FILL_W-1:0]    fill_cur;
    logic [FILL_W-1:0]    idx_reg;
    logic [KEY_WIDTH-1:0] rd_data_reg;
    logic [ADDR_W-1:0]    rd_addr, wr_addr;
    logic                 wr_en;
    logic [KEY_WIDTH-1:0] wr_data;
    logic                 ov_reg;
    logic [STATUS_W-1:0]  st_reg;
    logic [BIDX_W-1:0]    bidx_out_reg;
    logic [STATUS_W-1:0]  st_out_reg;
    logic                 done_go;

    assign fill_cur = fill_reg[bkt_reg];
    assign rd_addr  = {bkt_reg, SLOT_W'(idx_reg)};
    assign q_ready  = (state_reg == S_IDLE);
    assign out_valid = ov_reg;
    assign bucket_index = bidx_out_reg;
    assign status = st_out_reg;
    assign done_go = (state_reg == S_DONE) && (!ov_reg || out_ready);

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = {bkt_reg, SLOT_W'(idx_reg)};
        wr_data = key_reg;
        if (state_reg == S_WRITE)
            wr_en = 1'b1;
        else if (state_reg == S_MOVE)
        begin
            wr_en   = 1'b1;
            wr_addr = {bkt_reg, SLOT_W'(idx_reg - 1'b1)};
            wr_data = rd_data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            keys_mem[wr_addr] <= wr_data;
        rd_data_reg <= keys_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
            for (int i = 0; i < NUM_BUCKETS; i++)
                fill_reg[i] <= '0;
        end
        else
        begin
            if (done_go)
                ov_reg <= 1'b1;
            else if (ov_reg && out_ready)
                ov_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    func_reg <= q_func;
                    key_reg  <= q_key;
                    bkt_reg  <= q_bucket;
                    idx_reg  <= '0;
                    if (q_valid)
                        state_reg <= S_READ;
                end
                S_READ:
                begin
                    if (func_reg == FUNC_INSERT)
                    begin
                        if (fill_cur >= FILL_W'(BUCKET_DEPTH))
                        begin
                            st_reg    <= ST_FULL;
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            idx_reg   <= fill_cur;
                            state_reg <= S_WRITE;
                        end
                    end
                    else if (idx_reg >= fill_cur)
                    begin
                        st_reg    <= ST_NOT_FOUND;
                        state_reg <= S_DONE;
                    end
                    else
                        state_reg <= S_CMP;
                end
                S_CMP:
                begin
                    idx_reg <= idx_reg + 1'b1;
                    if (rd_data_reg == key_reg)
                        state_reg <= S_SHIFT;
                    else
                        state_reg <= S_READ;
                end
                S_SHIFT:
                begin
                    // Slot idx_reg is read here and written one place up in the next cycle.
                    if (idx_reg >= fill_cur)
                    begin
                        fill_reg[bkt_reg] <= fill_cur - 1'b1;
                        st_reg    <= ST_DELETED;
                        state_reg <= S_DONE;
                    end
                    else
                        state_reg <= S_MOVE;
                end
                S_MOVE:
                begin
                    idx_reg   <= idx_reg + 1'b1;
                    state_reg <= S_SHIFT;
                end
                S_WRITE:
                begin
                    fill_reg[bkt_reg] <= fill_cur + 1'b1;
                    st_reg    <= ST_INSERTED;
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (done_go)
                    begin
                        bidx_out_reg <= BIDX_W'(bkt_reg);
                        st_out_reg   <= st_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `include "chained_hash_table_engine_unit_defines.svh"
    `CHT_ASSERT_IMP(a_back_fill, clk, rst_n, state_reg != S_IDLE, 32'(fill_cur) <= BUCKET_DEPTH, "fill above depth")
    `CHT_ASSERT_NEXT(a_back_insert, clk, rst_n, state_reg == S_WRITE, st_reg == ST_INSERTED, "insert status lost")
    `CHT_ASSERT_IMP(a_back_idle, clk, rst_n, state_reg != S_IDLE, !q_ready, "back takes word while busy")

endmodule

// File: src/chained_hash_table_engine_unit.sv
// Chained hash table engine, top level: front hash unit, word queue, back table unit.
// Uses cht_pkg, cht_front, cht_queue and cht_back.
//
// Input words (func, key) arrive on valid/ready; each gives exactly one result
// word (bucket_index, status) on out_valid/out_ready, in order.
// Configuration words (cfg_index, cfg_data) on cfg_valid/cfg_ready set hash_mode
// (index 0) and bucket_count (index 1); cfg_ready is always high.
// The front hashes each word with a shift-add square or a square root when that
// mode is set, then in the modulo unit, a one-bit restoring divider; it takes
// a new word only once the last one has left it.
// The back then writes an insert into its bucket, or scans and shifts the bucket
// for a delete, overlapped with the next hash.
// A two-word queue parts the front and back, so each stalls independently.
// Reset empties every bucket at once; no clearing pass is needed.
// When the receiver stalls, the result is held, the back stops, the queue fills
// and then the input's ready falls.
module chained_hash_table_engine_unit #(
    parameter int NUM_BUCKETS  = cht_pkg::NUM_BUCKETS_DEF,
    parameter int BUCKET_DEPTH = cht_pkg::BUCKET_DEPTH_DEF,
    parameter int KEY_WIDTH    = cht_pkg::KEY_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic                         cfg_index,
    input  logic [cht_pkg::CNT_W-1:0]    cfg_data,
    input  logic                         valid,
    output logic                         ready,
    input  logic                         func,
    input  logic [cht_pkg::IN_KEY_W-1:0] key,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [cht_pkg::BIDX_W-1:0]   bucket_index,
    output logic [cht_pkg::STATUS_W-1:0] status
);
    import cht_pkg::*;

    localparam int BKT_W = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int QW    = 1 + KEY_WIDTH + BKT_W;

    logic [MODE_W-1:0] mode_reg;
    logic [CNT_W-1:0]  count_reg;

    logic                 f_valid, f_ready, b_valid, b_ready;
    logic                 f_func, b_func;
    logic [KEY_WIDTH-1:0] f_key, b_key;
    logic [BKT_W-1:0]     f_bkt, b_bkt;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_MOD;
            count_reg <= CNT_W'(10);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_HASH_MODE:    mode_reg  <= cfg_data[MODE_W-1:0];
                CFG_BUCKET_COUNT: count_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    cht_front #(.NUM_BUCKETS(NUM_BUCKETS), .KEY_WIDTH(KEY_WIDTH)) u_front (
        .clk(clk), .rst_n(rst_n), .hash_mode(mode_reg), .bucket_count(count_reg),
        .valid(valid), .ready(ready), .func(func), .key(key),
        .q_valid(f_valid), .q_ready(f_ready), .q_func(f_func), .q_key(f_key),
        .q_bucket(f_bkt)
    );

    cht_queue #(.WIDTH(QW)) u_queue (
        .clk(clk), .rst_n(rst_n),
        .in_valid(f_valid), .in_ready(f_ready), .in_data({f_func, f_key, f_bkt}),
        .out_valid(b_valid), .out_ready(b_ready), .out_data({b_func, b_key, b_bkt})
    );

    cht_back #(.NUM_BUCKETS(NUM_BUCKETS), .BUCKET_DEPTH(BUCKET_DEPTH),
               .KEY_WIDTH(KEY_WIDTH)) u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(b_valid), .q_ready(b_ready), .q_func(b_func), .q_key(b_key),
        .q_bucket(b_bkt),
        .out_valid(out_valid), .out_ready(out_ready),
        .bucket_index(bucket_index), .status(status)
    );
endmodule
